@@ src/ita_pkg.sv @@
// Shared constants, types and helpers for the integer to ASCII formatter.
`default_nettype none

package ita_pkg;

   localparam int NUM_W      = 64;
   localparam int SDEC_W     = 32;
   localparam int BCD_DIGITS = 20;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int CNT_W      = 7;

   typedef enum logic [1:0] {
      CMD_UDEC = 2'd0,
      CMD_SDEC = 2'd1,
      CMD_HEX  = 2'd2,
      CMD_BIN  = 2'd3
   } cmd_type;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_UPPER = 8'h41;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // ASCII for one hex or decimal digit
   function automatic logic [7:0] nibble_char(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = CHAR_ZERO + {4'd0, nib};
      end else begin
         ch = CHAR_UPPER + {4'd0, nib - 4'd10};
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

@@ src/ita_bcd_step.sv @@
// One shift-add-3 step of the binary to BCD converter.
`default_nettype none

module ita_bcd_step
   import ita_pkg::*;
(
   input  wire logic [BCD_W-1:0] bcd,
   input  wire logic             bin_msb,
   output logic      [BCD_W-1:0] bcd_next
);

   logic [BCD_W-1:0] adj;

   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd[4*i +: 4];
         end
      end
   end

   assign bcd_next = {adj[BCD_W-2:0], bin_msb};

endmodule

`default_nettype wire

@@ src/integer_to_ascii_formatter.sv @@
// Top level: formats a 64-bit value as ASCII text, one character per rsp_valid pulse.
//
// Usage: drive req_cmd and req_number with start high; the beat is taken on
// a rising edge where busy is low. Characters then appear most significant
// first on rsp_ascii_char, each for exactly one cycle with rsp_valid high;
// rsp_last marks the final character. The receiver cannot stall the output.
// Decimal modes run a shift-add-3 converter one bit per cycle over all 64
// bits, then skip leading zero digits (up to 19), send a '-' in signed mode
// and send the digits. Hex walks a 20 nibble window, skipping leading
// zeros silently; binary sends 64 characters. busy drops in the cycle
// that carries the last character, so a new beat may start on the edge
// that ends that cycle.
// Reset (synchronous, active high) returns the block to idle and drops any
// conversion in flight.
`default_nettype none

module integer_to_ascii_formatter
   import ita_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        req_cmd,
   input  wire logic [NUM_W-1:0]  req_number,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_ascii_char,
   output logic                   rsp_last
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CONV = 4'b0010,
      S_SIGN = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [NUM_W-1:0]    bin_ff, bin_in;
   logic [BCD_W-1:0]    bcd_ff, bcd_in;
   cmd_type             mode_ff, mode_in;
   logic                neg_ff, neg_in;
   logic                lead_ff, lead_in;
   logic                valid_ff, valid_in;
   logic [7:0]          char_ff, char_in;
   logic                last_ff, last_in;

   logic [BCD_W-1:0]    bcd_step;
   logic [SDEC_W-1:0]   low;
   logic [SDEC_W-1:0]   mag;
   logic [3:0]          digit;
   logic                is_bin;

   ita_bcd_step u_step (
      .bcd      (bcd_ff),
      .bin_msb  (bin_ff[NUM_W-1]),
      .bcd_next (bcd_step)
   );

   assign low    = req_number[SDEC_W-1:0];
   assign mag    = low[SDEC_W-1] ? (~low + {{(SDEC_W-1){1'b0}}, 1'b1}) : low;
   assign digit  = bcd_ff[BCD_W-1 -: 4];
   assign is_bin = (mode_ff == CMD_BIN);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      mode_in  = mode_ff;
      neg_in   = neg_ff;
      lead_in  = lead_ff;
      valid_in = 1'b0;
      char_in  = char_ff;
      last_in  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in = cmd_type'(req_cmd);
               neg_in  = 1'b0;
               lead_in = 1'b1;
               case (cmd_type'(req_cmd))
                  CMD_UDEC: begin
                     bin_in   = req_number;
                     bcd_in   = '0;
                     cnt_in   = CNT_W'(NUM_W);
                     state_in = S_CONV;
                  end
                  CMD_SDEC: begin
                     bin_in   = {{(NUM_W-SDEC_W){1'b0}}, mag};
                     bcd_in   = '0;
                     neg_in   = low[SDEC_W-1];
                     cnt_in   = CNT_W'(NUM_W);
                     state_in = S_CONV;
                  end
                  CMD_HEX: begin
                     bcd_in   = {{(BCD_W-NUM_W){1'b0}}, req_number};
                     cnt_in   = CNT_W'(BCD_DIGITS);
                     state_in = S_OUT;
                  end
                  default: begin
                     bcd_in   = {req_number, {(BCD_W-NUM_W){1'b0}}};
                     cnt_in   = CNT_W'(NUM_W);
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_CONV: begin
            bcd_in = bcd_step;
            bin_in = {bin_ff[NUM_W-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               cnt_in   = CNT_W'(BCD_DIGITS);
               state_in = neg_ff ? S_SIGN : S_OUT;
            end
         end
         S_SIGN: begin
            valid_in = 1'b1;
            char_in  = CHAR_MINUS;
            state_in = S_OUT;
         end
         S_OUT: begin
            cnt_in = cnt_ff - CNT_W'(1);
            if (is_bin) begin
               bcd_in   = {bcd_ff[BCD_W-2:0], 1'b0};
               valid_in = 1'b1;
               char_in  = CHAR_ZERO + {7'd0, bcd_ff[BCD_W-1]};
            end else begin
               bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
               // leading zeros are dropped, but the units digit always goes out
               if (!(lead_ff && digit == 4'd0 && cnt_ff != CNT_W'(1))) begin
                  valid_in = 1'b1;
                  lead_in  = 1'b0;
                  char_in  = nibble_char(digit);
               end
            end
            if (cnt_ff == CNT_W'(1)) begin
               last_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
         cnt_ff   <= '0;
         lead_ff  <= 1'b0;
         neg_ff   <= 1'b0;
         mode_ff  <= CMD_UDEC;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         last_ff  <= last_in;
         cnt_ff   <= cnt_in;
         lead_ff  <= lead_in;
         neg_ff   <= neg_in;
         mode_ff  <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      char_ff <= char_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = valid_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

@@ tb/tb_integer_to_ascii_formatter.sv @@
// Self-checking testbench for integer_to_ascii_formatter: directed table, then random bursts.
module tb_integer_to_ascii_formatter
   import ita_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 200;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 150;
   localparam int ROW_COUNT    = 21;
   localparam int MAX_PRINTS   = 40;

   localparam logic [7:0] ASC_ZERO  = "0";
   localparam logic [7:0] ASC_A     = "A";
   localparam logic [7:0] ASC_MINUS = "-";

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } text_char_type;

   // text of 0 means the row is checked against the predictor
   typedef struct packed {
      cmd_type      cmd;
      logic [63:0]  number;
      logic [159:0] text;
   } format_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_cmd;
   logic [NUM_W-1:0]  req_number;
   logic              rsp_valid;
   logic [7:0]        rsp_ascii_char;
   logic              rsp_last;

   logic [159:0]      row_text;
   text_char_type     expected_chars[$];
   text_char_type     want;
   int                error_count;
   int                cycle_count = 0;
   int                items_left;
   int                burst;

   format_row_type format_rows [ROW_COUNT] = '{
      '{CMD_UDEC, 64'd0,                   "0"},
      '{CMD_UDEC, 64'd9,                   "9"},
      '{CMD_UDEC, 64'd10,                  "10"},
      '{CMD_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, "18446744073709551615"},
      '{CMD_UDEC, 64'd10000000000000000000, "10000000000000000000"},
      '{CMD_UDEC, 64'h8000_0000_0000_0000, '0},
      '{CMD_SDEC, 64'd0,                   "0"},
      '{CMD_SDEC, 64'h0000_0000_8000_0000, "-2147483648"},
      '{CMD_SDEC, 64'h0000_0000_FFFF_FFFF, "-1"},
      '{CMD_SDEC, 64'h0000_0000_7FFF_FFFF, "2147483647"},
      '{CMD_SDEC, 64'hFFFF_FFFF_0000_0005, "5"},
      '{CMD_SDEC, 64'h1234_5678_8000_0001, '0},
      '{CMD_HEX,  64'd0,                   "0"},
      '{CMD_HEX,  64'hFFFF_FFFF_FFFF_FFFF, "FFFFFFFFFFFFFFFF"},
      '{CMD_HEX,  64'h0123_4567_89AB_CDEF, "123456789ABCDEF"},
      '{CMD_HEX,  64'hA,                   "A"},
      '{CMD_BIN,  64'd0,                   '0},
      '{CMD_BIN,  64'hFFFF_FFFF_FFFF_FFFF, '0},
      '{CMD_BIN,  64'd1,                   '0},
      '{CMD_BIN,  64'h8000_0000_0000_0000, '0},
      '{CMD_UDEC, 64'd99999,               '0}
   };

   integer_to_ascii_formatter dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_number     (req_number),
      .rsp_valid      (rsp_valid),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTS) begin
         $display("[%0d] mismatch: %s", cycle_count, msg);
      end
      error_count++;
   endtask

   // Queues the characters of one value, most significant first
   function automatic void predict_text(input cmd_type cmd, input logic [63:0] num);
      logic [7:0]  rev [64];
      logic [63:0] v;
      logic [63:0] digit;
      logic [31:0] low;
      logic        neg;
      int          n;
      neg = 1'b0;
      v   = num;
      if (cmd == CMD_SDEC) begin
         low = num[31:0];
         if (low[31]) begin
            neg = 1'b1;
            low = -low;
         end
         v = {32'd0, low};
      end
      n = 0;
      if (cmd == CMD_BIN) begin
         for (n = 0; n < 64; n++) begin
            rev[n] = ASC_ZERO + {7'd0, v[0]};
            v = v >> 1;
         end
      end else if (cmd == CMD_HEX) begin
         do begin
            digit  = {60'd0, v[3:0]};
            rev[n] = (digit < 10) ? ASC_ZERO + digit[7:0] : ASC_A + digit[7:0] - 8'd10;
            n++;
            v = v >> 4;
         end while (v != 0);
      end else begin
         do begin
            digit  = v % 64'd10;
            rev[n] = ASC_ZERO + digit[7:0];
            n++;
            v = v / 64'd10;
         end while (v != 0);
      end
      if (neg) begin
         expected_chars.push_back('{ASC_MINUS, 1'b0});
      end
      for (int k = n - 1; k >= 0; k--) begin
         expected_chars.push_back('{rev[k], k == 0});
      end
   endfunction

   // Typed text sits right-aligned in the vector, zero bytes to the left
   function automatic void queue_typed_text(input logic [159:0] txt);
      int hi;
      hi = 0;
      for (int i = 0; i < 20; i++) begin
         if (txt[8*i +: 8] != 8'd0) begin
            hi = i;
         end
      end
      for (int i = hi; i >= 0; i--) begin
         expected_chars.push_back('{txt[8*i +: 8], i == 0});
      end
   endfunction

   function automatic logic [63:0] random_number();
      logic [63:0] v;
      case ($urandom_range(0, 5))
         0: v = {$urandom, $urandom};
         1: v = {32'd0, $urandom_range(0, 20)};
         2: v = (64'd1 << $urandom_range(0, 63)) - {63'd0, 1'($urandom_range(0, 1))};
         3: v = {$urandom, 32'h8000_0000 ^ $urandom_range(0, 3)};
         4: v = {32'd0, $urandom};
         default: v = ~{32'd0, $urandom_range(0, 1000)};
      endcase
      return v;
   endfunction

   task automatic send_beat(input cmd_type cmd, input logic [63:0] num, input logic [159:0] txt);
      @(negedge clock);
      start      <= 1'b1;
      req_cmd    <= cmd;
      req_number <= num;
      row_text   <= txt;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic idle_for(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (expected_chars.size() != 0) @(negedge clock);
   endtask

   // Beat acceptance and character checking share one process so ordering is fixed
   always @(posedge clock) begin
      if (!reset) begin
         if (start && busy === 1'b0) begin
            if (row_text != '0) begin
               queue_typed_text(row_text);
            end else begin
               predict_text(cmd_type'(req_cmd), req_number);
            end
         end
         if (rsp_valid === 1'b1) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected char 0x%02h last %b",
                                         rsp_ascii_char, rsp_last));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_ascii_char !== want.ch) begin
                  report_mismatch($sformatf("char 0x%02h, wanted 0x%02h",
                                            rsp_ascii_char, want.ch));
               end
               if (rsp_last !== want.last) begin
                  report_mismatch($sformatf("last %b, wanted %b on char 0x%02h",
                                            rsp_last, want.last, want.ch));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** integer_to_ascii_formatter: FAILED **");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_cmd     = CMD_UDEC;
      req_number  = '0;
      row_text    = '0;
      error_count = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows go back to back, start held high throughout
      for (int r = 0; r < ROW_COUNT; r++) begin
         send_beat(format_rows[r].cmd, format_rows[r].number, format_rows[r].text);
      end
      wait_drained();

      items_left = RANDOM_ITEMS;
      while (items_left > 0) begin
         burst = $urandom_range(1, 10);
         while (burst > 0 && items_left > 0) begin
            send_beat(cmd_type'($urandom_range(0, 3)), random_number(), '0);
            burst--;
            items_left--;
            if (items_left == RANDOM_ITEMS / 2) begin
               wait_drained();
            end
         end
         case ($urandom_range(0, 3))
            1: idle_for($urandom_range(1, 5));
            2: idle_for($urandom_range(20, 150));
            default: ;
         endcase
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_chars.size() != 0) begin
         report_mismatch($sformatf("%0d chars never arrived", expected_chars.size()));
      end
      if (error_count == 0) begin
         $display("** integer_to_ascii_formatter: PASSED **");
      end else begin
         $display("** integer_to_ascii_formatter: FAILED **");
      end
      $finish;
   end

endmodule
